### rtl/core/bprr_pkg.sv
// ----------------------------------------------------------------------------
// bprr_pkg
// Shared types and constants of the boot probe round-robin sequencer.
// ----------------------------------------------------------------------------
package bprr_pkg;

  // Timestamp width kept for elapsed-time arithmetic
  localparam int TIME_WIDTH    = 32;
  // Width of the slot zero attempt counter
  localparam int ATTEMPT_WIDTH = 8;

  // Fixed field and register widths
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 32;
  localparam int LIMIT_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SLOT_N   = 3;
  localparam int SLOT_W   = 2;

  // Compare widths that hold both sides of a compare
  localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam int ACMP_W = (ATTEMPT_WIDTH > LIMIT_W) ? ATTEMPT_WIDTH : LIMIT_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd3;

  // Configuration reset values
  localparam logic [CFG_W-1:0]   SETTLE_RST  = 32'd100000;
  localparam logic [CFG_W-1:0]   MAX_RST     = 32'd5000000;
  localparam logic [CFG_W-1:0]   RETRY_RST   = 32'd100000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 8'd3;

  // Slot codes
  localparam logic [SLOT_W-1:0] SLOT_DEV0 = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_DEV1 = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DEV2 = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]   settle_time;
    logic [CFG_W-1:0]   max_time;
    logic [CFG_W-1:0]   retry_period;
    logic [LIMIT_W-1:0] attempt_limit;
  } cfg_t;

  typedef struct packed {
    logic                     started;
    logic [TIME_WIDTH-1:0]    start_stamp;
    logic [SLOT_N-1:0]        resolved;
    logic [SLOT_W-1:0]        cursor;
    logic [ATTEMPT_WIDTH-1:0] attempts;
    logic [TIME_WIDTH-1:0]    last_stamp;
  } seq_state_t;

  typedef struct packed {
    logic [NOW_W-1:0] now_time;
    logic             dev0_connected;
    logic             dev1_ready;
    logic             dev2_ready;
  } tick_t;

  typedef struct packed {
    logic              probe_valid;
    logic [SLOT_W-1:0] probe_slot;
    logic              forced_out;
    logic              all_resolved;
  } result_t;

endpackage

### rtl/core/bprr_step.sv
// ----------------------------------------------------------------------------
// bprr_step
// Decision logic for one tick: settle and timeout checks, round-robin pick
// of the first unresolved due slot, and the probe's effect on the state.
// ----------------------------------------------------------------------------
module bprr_step (
  input  bprr_pkg::cfg_t       cfg,
  input  bprr_pkg::seq_state_t cur,
  input  bprr_pkg::tick_t      tick,
  output bprr_pkg::seq_state_t nxt,
  output bprr_pkg::result_t    res
);

  logic [bprr_pkg::TIME_WIDTH-1:0] now;
  logic [bprr_pkg::TIME_WIDTH-1:0] start_eff;
  logic [bprr_pkg::TIME_WIDTH-1:0] since;
  logic [bprr_pkg::TIME_WIDTH-1:0] since_last;
  logic                            settled;
  logic                            timed_out;
  logic                            dev0_due;
  logic [bprr_pkg::SLOT_N-1:0]     eligible;
  logic [bprr_pkg::ATTEMPT_WIDTH-1:0] attempts_inc;

  assign now        = bprr_pkg::TIME_WIDTH'(tick.now_time);
  assign start_eff  = cur.started ? cur.start_stamp : now;
  assign since      = now - start_eff;
  assign since_last = now - cur.last_stamp;
  assign settled    = bprr_pkg::CMP_W'(since) >= bprr_pkg::CMP_W'(cfg.settle_time);
  assign timed_out  = bprr_pkg::CMP_W'(since) >= bprr_pkg::CMP_W'(cfg.max_time);
  assign dev0_due   = (cur.attempts == '0) ||
                      (bprr_pkg::CMP_W'(since_last) >= bprr_pkg::CMP_W'(cfg.retry_period));

  // A slot is a candidate when unresolved; slot zero must also be due
  assign eligible = {~cur.resolved[2], ~cur.resolved[1], ~cur.resolved[0] & dev0_due};

  // Saturating attempt count after a slot zero probe
  assign attempts_inc = (&cur.attempts) ? cur.attempts :
                        cur.attempts + bprr_pkg::ATTEMPT_WIDTH'(1);

  always_comb begin
    logic [bprr_pkg::SLOT_W-1:0] base;
    logic [bprr_pkg::SLOT_W:0]   sum;
    logic [bprr_pkg::SLOT_W-1:0] slot;
    logic [bprr_pkg::SLOT_W-1:0] pick;
    logic                        found;

    nxt          = cur;
    nxt.started  = 1'b1;
    nxt.start_stamp = start_eff;
    res          = '0;
    found        = 1'b0;
    pick         = bprr_pkg::SLOT_DEV0;
    base         = (cur.cursor == 2'd3) ? bprr_pkg::SLOT_DEV0 : cur.cursor;

    // Walk the three slots from the cursor, keep the first candidate
    for (int i = 0; i < bprr_pkg::SLOT_N; i++) begin
      sum = {1'b0, base} + (bprr_pkg::SLOT_W + 1)'(i);
      if (sum >= (bprr_pkg::SLOT_W + 1)'(bprr_pkg::SLOT_N)) begin
        sum = sum - (bprr_pkg::SLOT_W + 1)'(bprr_pkg::SLOT_N);
      end
      slot = sum[bprr_pkg::SLOT_W-1:0];
      if (!found && eligible[slot]) begin
        found = 1'b1;
        pick  = slot;
      end
    end

    if (!(&cur.resolved) && settled) begin
      if (timed_out) begin
        // Force every slot resolved
        nxt.resolved   = '1;
        res.forced_out = 1'b1;
      end else if (found) begin
        res.probe_valid = 1'b1;
        res.probe_slot  = pick;
        nxt.cursor      = (pick == bprr_pkg::SLOT_DEV2) ? bprr_pkg::SLOT_DEV0 :
                          pick + bprr_pkg::SLOT_W'(1);
        case (pick)
          bprr_pkg::SLOT_DEV0: begin
            nxt.attempts   = attempts_inc;
            nxt.last_stamp = now;
            if (tick.dev0_connected ||
                (bprr_pkg::ACMP_W'(attempts_inc) >= bprr_pkg::ACMP_W'(cfg.attempt_limit))) begin
              nxt.resolved[0] = 1'b1;
            end
          end
          bprr_pkg::SLOT_DEV1: begin
            if (tick.dev1_ready) nxt.resolved[1] = 1'b1;
          end
          bprr_pkg::SLOT_DEV2: begin
            if (tick.dev2_ready) nxt.resolved[2] = 1'b1;
          end
          default: begin
            nxt.cursor = cur.cursor;
          end
        endcase
      end
    end

    res.all_resolved = &nxt.resolved;
  end

endmodule

### rtl/core/boot_probe_round_robin_sequencer.sv
// ----------------------------------------------------------------------------
// boot_probe_round_robin_sequencer
// Probes three boot devices in round-robin order, one tick per request.
// ----------------------------------------------------------------------------
// Each input request is one tick and yields exactly one result. The block
// takes one tick per clock cycle unless the result side stalls; a tick is
// held in the input register, its result then in the result register. The
// sustained rate is set by the sequencer state loop, which the combinational
// step logic updates once per tick as it passes from the input register to
// the result register. A held result still lets one more tick be registered;
// after that the input stalls until the result is taken. Configuration is
// written through a plain write port and takes effect on the next tick.
module boot_probe_round_robin_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: now_time[31:0], dev0_connected[32], dev1_ready[33],
  //           dev2_ready[34], zero fill[39:35]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: probe_valid[0], probe_slot[2:1], forced_out[3],
  //            all_resolved[4], zero fill[7:5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [bprr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bprr_pkg::CFG_W-1:0]     cfg_wdata
);

  bprr_pkg::cfg_t       cfg_r;
  bprr_pkg::seq_state_t state_r;
  bprr_pkg::seq_state_t state_nxt;
  bprr_pkg::tick_t      tick_r;
  bprr_pkg::result_t    res_nxt;
  bprr_pkg::result_t    res_r;
  logic                 in_v_r;
  logic                 out_v_r;
  logic                 advance;

  // Move the held tick into the result register when it has room
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_time   <= bprr_pkg::SETTLE_RST;
      cfg_r.max_time      <= bprr_pkg::MAX_RST;
      cfg_r.retry_period  <= bprr_pkg::RETRY_RST;
      cfg_r.attempt_limit <= bprr_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bprr_pkg::REG_SETTLE_TIME:   cfg_r.settle_time   <= cfg_wdata;
        bprr_pkg::REG_MAX_TIME:      cfg_r.max_time      <= cfg_wdata;
        bprr_pkg::REG_RETRY_PERIOD:  cfg_r.retry_period  <= cfg_wdata;
        bprr_pkg::REG_ATTEMPT_LIMIT: cfg_r.attempt_limit <= cfg_wdata[bprr_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r.now_time       <= in_tdata[31:0];
      tick_r.dev0_connected <= in_tdata[32];
      tick_r.dev1_ready     <= in_tdata[33];
      tick_r.dev2_ready     <= in_tdata[34];
    end
  end

  bprr_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .tick (tick_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Advance the sequencer state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, res_r.all_resolved, res_r.forced_out,
                       res_r.probe_slot, res_r.probe_valid};

endmodule
